/* rtl/core/owb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_pkg: shared types and constants of the one-wire bus master
// Transaction payload types, phase and command codes, register indexes and
// register reset values.
// ----------------------------------------------------------------------------
package owb_pkg;

    localparam int CFG_W = 10;

    // Command codes carried in the action field.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // Bus phase codes.
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_RST_LOW    = 4'd1;
    localparam logic [3:0] PH_RST_WAIT   = 4'd2;
    localparam logic [3:0] PH_RST_REC    = 4'd3;
    localparam logic [3:0] PH_GUARD_PRE  = 4'd4;
    localparam logic [3:0] PH_SLOT_START = 4'd5;
    localparam logic [3:0] PH_W_HOLD     = 4'd6;
    localparam logic [3:0] PH_GUARD_POST = 4'd7;
    localparam logic [3:0] PH_R_DELAY    = 4'd8;
    localparam logic [3:0] PH_R_HOLD     = 4'd9;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] CFG_RESET_REC     = 3'd2;
    localparam logic [2:0] CFG_SLOT_START    = 3'd3;
    localparam logic [2:0] CFG_SLOT_HOLD     = 3'd4;
    localparam logic [2:0] CFG_READ_SAMPLE   = 3'd5;
    localparam logic [2:0] CFG_GUARD         = 3'd6;

    // Register reset values in microseconds.
    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd500;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd100;
    localparam logic [CFG_W-1:0] RST_RESET_REC     = 10'd400;
    localparam logic [CFG_W-1:0] RST_SLOT_START    = 10'd6;
    localparam logic [CFG_W-1:0] RST_SLOT_HOLD     = 10'd90;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd7;
    localparam logic [CFG_W-1:0] RST_GUARD         = 10'd10;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_wait_time;
        logic [CFG_W-1:0] reset_recovery_time;
        logic [CFG_W-1:0] slot_start_time;
        logic [CFG_W-1:0] slot_hold_time;
        logic [CFG_W-1:0] read_sample_delay;
        logic [CFG_W-1:0] guard_time;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
    } out_item_t;

    // Bus engine state apart from the timer.
    typedef struct packed {
        logic [3:0] phase;
        logic [1:0] operation;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic       presence_flag;
        logic       line_drive;
        logic [7:0] read_hold;
    } state_t;

endpackage

/* rtl/core/owb_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_cfg_regs: timing register file
// Seven write-only timing registers with their reset values.
// ----------------------------------------------------------------------------
module owb_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [owb_pkg::CFG_W-1:0]      cfg_data,
    output owb_pkg::cfg_t                  cfg
);
    import owb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_LOW:     cfg_next.reset_low_time      = cfg_data;
                CFG_PRESENCE_WAIT: cfg_next.presence_wait_time  = cfg_data;
                CFG_RESET_REC:     cfg_next.reset_recovery_time = cfg_data;
                CFG_SLOT_START:    cfg_next.slot_start_time     = cfg_data;
                CFG_SLOT_HOLD:     cfg_next.slot_hold_time      = cfg_data;
                CFG_READ_SAMPLE:   cfg_next.read_sample_delay   = cfg_data;
                CFG_GUARD:         cfg_next.guard_time          = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time      <= RST_RESET_LOW;
            cfg_reg.presence_wait_time  <= RST_PRESENCE_WAIT;
            cfg_reg.reset_recovery_time <= RST_RESET_REC;
            cfg_reg.slot_start_time     <= RST_SLOT_START;
            cfg_reg.slot_hold_time      <= RST_SLOT_HOLD;
            cfg_reg.read_sample_delay   <= RST_READ_SAMPLE;
            cfg_reg.guard_time          <= RST_GUARD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/owb_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_step: next-state logic of the bus engine
// Applies one transaction to the engine state. Phases of zero length are
// resolved in closed form, so a chain of them finishes within one pass.
// ----------------------------------------------------------------------------
module owb_step #(
    parameter int TIMER_BITS = 10
) (
    input  owb_pkg::cfg_t           cfg,
    input  owb_pkg::in_item_t       item,
    input  owb_pkg::state_t         st,
    input  logic [TIMER_BITS-1:0]   time_left,
    output owb_pkg::state_t         st_next,
    output logic [TIMER_BITS-1:0]   time_left_next,
    output logic                    done
);
    import owb_pkg::*;

    localparam logic [16:0] TMAX = (17'd1 << TIMER_BITS) - 17'd1;

    // Durations above the timer range saturate to its maximum.
    function automatic logic [TIMER_BITS-1:0] clamp_time(input logic [CFG_W-1:0] v);
        logic [16:0] ext;
        ext = 17'(v);
        if (ext > TMAX)
            return TMAX[TIMER_BITS-1:0];
        else
            return ext[TIMER_BITS-1:0];
    endfunction

    logic             run;
    logic             stray;
    logic [2:0]       s;
    logic             rd;
    logic [CFG_W-1:0] dur [4];
    logic             found;
    logic [1:0]       j;
    logic             any_nz;
    logic [1:0]       j0;
    logic [1:0]       stop;
    logic             finished;
    logic [3:0]       m;
    logic [3:0]       w;
    logic [3:0]       bc1;
    logic [3:0]       rest;
    logic [3:0]       amt;
    logic [7:0]       sb_new;

    always_comb
    begin
        st_next        = st;
        time_left_next = time_left;
        done           = 1'b0;
        run            = 1'b0;
        stray          = 1'b0;
        s              = 3'd0;

        // Where a phase has ended, s is the slot position from which the
        // search for the next phase with time on it starts.
        if (item.action == ACT_TICK)
        begin
            if (st.phase != PH_IDLE)
            begin
                if (time_left != '0)
                    time_left_next = time_left - TIMER_BITS'(1);
                if (time_left_next == '0)
                begin
                    run = 1'b1;
                    case (st.phase)
                        PH_RST_LOW:    s = 3'd1;
                        PH_RST_WAIT:   s = 3'd2;
                        PH_RST_REC:    s = 3'd3;
                        PH_GUARD_PRE:  s = 3'd1;
                        PH_SLOT_START: s = 3'd2;
                        PH_W_HOLD:     s = 3'd3;
                        PH_R_DELAY:    s = 3'd3;
                        PH_GUARD_POST: s = 3'd4;
                        PH_R_HOLD:     s = 3'd4;
                        default:       stray = 1'b1;
                    endcase
                end
            end
        end
        else if (st.phase == PH_IDLE)
        begin
            run                = 1'b1;
            st_next.operation  = item.action;
            st_next.bit_count  = 4'd0;
            st_next.shift_byte = (item.action == ACT_WRITE) ? item.data_byte : 8'd0;
        end

        rd = (st_next.operation == ACT_READ);

        if (st_next.operation == ACT_RESET)
        begin
            dur[0] = cfg.reset_low_time;
            dur[1] = cfg.presence_wait_time;
            dur[2] = cfg.reset_recovery_time;
            dur[3] = '0;
        end
        else
        begin
            dur[0] = cfg.guard_time;
            dur[1] = cfg.slot_start_time;
            dur[2] = rd ? cfg.read_sample_delay : cfg.slot_hold_time;
            dur[3] = rd ? cfg.slot_hold_time : cfg.guard_time;
        end

        found  = 1'b0;
        j      = 2'd0;
        any_nz = 1'b0;
        j0     = 2'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (!found && (k >= int'(s)) && (dur[k] != '0))
            begin
                found = 1'b1;
                j     = 2'(k);
            end
            if (!any_nz && (dur[k] != '0))
            begin
                any_nz = 1'b1;
                j0     = 2'(k);
            end
        end

        // Slot bookkeeping: m bits sampled, w bits shifted out.
        finished = 1'b0;
        m        = 4'd0;
        w        = 4'd0;
        stop     = j;
        bc1      = st_next.bit_count + 4'd1;
        rest     = 4'd8 - bc1;
        if (found)
        begin
            m = {3'd0, rd && (s <= 3'd3) && (j > 2'd2)};
        end
        else
        begin
            m = {3'd0, rd && (s <= 3'd3)};
            w = {3'd0, !rd};
            if (bc1 >= 4'd8)
            begin
                finished = 1'b1;
            end
            else if (any_nz)
            begin
                m    = m + {3'd0, rd && (j0 > 2'd2)};
                stop = j0;
            end
            else
            begin
                // Every remaining slot is of zero length.
                finished = 1'b1;
                if (rd)
                    m = m + rest;
                else
                    w = w + rest;
            end
        end
        amt    = rd ? m : w;
        sb_new = (st_next.shift_byte >> amt)
               | ((rd && item.line_level) ? ~(8'hFF >> amt) : 8'h00);

        if (run)
        begin
            if (stray)
            begin
                st_next.phase      = PH_IDLE;
                st_next.line_drive = 1'b0;
                time_left_next     = '0;
                done               = 1'b1;
            end
            else if (st_next.operation == ACT_RESET)
            begin
                if ((s <= 3'd2) && (!found || j > 2'd1))
                    st_next.presence_flag = !item.line_level;
                if (found && j != 2'd3)
                begin
                    case (j)
                        2'd0:    st_next.phase = PH_RST_LOW;
                        2'd1:    st_next.phase = PH_RST_WAIT;
                        default: st_next.phase = PH_RST_REC;
                    endcase
                    st_next.line_drive = (j == 2'd0);
                    time_left_next     = clamp_time(dur[j]);
                end
                else
                begin
                    st_next.phase      = PH_IDLE;
                    st_next.line_drive = 1'b0;
                    time_left_next     = '0;
                    done               = 1'b1;
                end
            end
            else
            begin
                st_next.shift_byte = sb_new;
                if (finished)
                begin
                    st_next.bit_count  = 4'd8;
                    st_next.phase      = PH_IDLE;
                    st_next.line_drive = 1'b0;
                    time_left_next     = '0;
                    done               = 1'b1;
                    if (rd)
                        st_next.read_hold = sb_new;
                end
                else
                begin
                    if (!found)
                        st_next.bit_count = bc1;
                    case (stop)
                        2'd0:    st_next.phase = PH_GUARD_PRE;
                        2'd1:    st_next.phase = PH_SLOT_START;
                        2'd2:    st_next.phase = rd ? PH_R_DELAY : PH_W_HOLD;
                        default: st_next.phase = rd ? PH_R_HOLD : PH_GUARD_POST;
                    endcase
                    st_next.line_drive = (stop == 2'd1)
                                       || ((stop == 2'd2) && !rd && !sb_new[0]);
                    time_left_next     = clamp_time(dur[stop]);
                end
            end
        end
    end

endmodule

/* rtl/core/one_wire_bus_master.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master: open-drain one-wire bus master
// Reset pulse with presence detect, byte write and byte read, timed by
// one-microsecond tick transactions.
// ----------------------------------------------------------------------------
// Usage: the command channel (cmd_valid, cmd_stall, cmd_item) carries one
// transaction per cycle unless stalled: a tick each microsecond, or a reset,
// write-byte or read-byte command. A command during an operation is ignored.
// The result channel (res_valid, res_stall, res_item) returns exactly one
// transaction per command transaction: the line drive, busy, a done flag on
// the transaction that completes an operation, the presence flag of the last
// reset and the byte of the last completed read.
// A result passes through the input register and then the result register;
// one transaction is taken per cycle while cmd_stall is low. The step logic
// resolves a whole chain of zero-length phases in one pass through the input
// and result registers. When the receiver stalls, the result register holds
// its transaction and one more transaction waits in the input register;
// after that cmd_stall is raised. Reset returns the engine to idle with the
// line released, and loads the timing registers with their default values.
// The user is to write the timing registers through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int TIMER_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  owb_pkg::in_item_t          cmd_item,
    output logic                       res_valid,
    input  logic                       res_stall,
    output owb_pkg::out_item_t         res_item,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [owb_pkg::CFG_W-1:0]  cfg_data
);
    import owb_pkg::*;

    cfg_t                  cfg;

    // Input register: one accepted transaction waiting for the step logic.
    logic                  cmd_valid_reg;
    in_item_t              cmd_reg;

    // Engine state.
    state_t                state_reg;
    state_t                state_next;
    logic [TIMER_BITS-1:0] time_left_reg;
    logic [TIMER_BITS-1:0] time_left_next;
    logic                  done;

    // Result register.
    logic                  res_valid_reg;
    out_item_t             res_reg;

    logic                  advance;
    logic                  accept;

    owb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owb_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg            (cfg),
        .item           (cmd_reg),
        .st             (state_reg),
        .time_left      (time_left_reg),
        .st_next        (state_next),
        .time_left_next (time_left_next),
        .done           (done)
    );

    // The waiting transaction moves on whenever the result register is free
    // or is being emptied in this cycle.
    assign advance   = cmd_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = cmd_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
            time_left_reg <= '0;
        end
        else
        begin
            if (accept)
                cmd_valid_reg <= 1'b1;
            else if (advance)
                cmd_valid_reg <= 1'b0;

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
                time_left_reg <= time_left_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_item;
        if (advance)
        begin
            res_reg.drive_low <= state_next.line_drive;
            res_reg.busy_res  <= (state_next.phase != PH_IDLE);
            res_reg.done_res  <= done;
            res_reg.presence  <= state_next.presence_flag;
            res_reg.read_data <= state_next.read_hold;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

/* tb/one_wire_bus_master_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_test: self-checking bench for the one-wire bus master
// A directed table covers the state after reset, zero-length timings, the
// unused register index, ignored commands and presence sampling. Random
// phases then run well-formed reset, write and read operations, with random
// bus levels and stray commands, under many timing settings. Every result
// transaction is checked against a typed-in value or a cycle-free bus model.
// ----------------------------------------------------------------------------
module one_wire_bus_master_test;
    import owb_pkg::*;

    localparam int CYCLE_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 8;    // well past the drain of the input and result registers
    localparam int HOLD_CYCLES  = 100;  // long receiver hold-off
    localparam int TMR_BITS     = 10;
    localparam int DIR_ROWS     = 25;
    localparam int MAX_SHOWN    = 10;
    localparam int TIMED_MIN    = 45;   // minimum timed transactions per random phase

    // Index 7 exists on the port but selects no register.
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG_ALL, ROW_CFG_ONE} row_kind_t;

    // One row of the directed table. Item rows either carry a typed-in
    // expectation or leave the expectation to the bus model.
    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [9:0]  reg_val;
        in_item_t    item;
        logic        typed;
        out_item_t   want;
    } dir_row_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    in_item_t   cmd_item = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    out_item_t  res_item;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    one_wire_bus_master u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Idle percentages of the two sides, and the request for a long hold-off.
    int snd_idle = 0;
    int rcv_idle = 0;
    bit hold_req = 1'b0;

    out_item_t pending_res[$];
    int        err_count = 0;
    int        shown = 0;
    int        timed_items = 0;
    int        cycles = 0;

    // ------------------------------------------------------------------------
    // Bus engine model: timing registers and engine state after each item.
    // ------------------------------------------------------------------------
    cfg_t timing = '{RST_RESET_LOW, RST_PRESENCE_WAIT, RST_RESET_REC, RST_SLOT_START,
                     RST_SLOT_HOLD, RST_READ_SAMPLE, RST_GUARD};

    logic [3:0] p_phase = PH_IDLE;
    logic [1:0] p_op = ACT_TICK;
    logic [9:0] p_left = '0;
    logic [3:0] p_bits = '0;
    logic [7:0] p_shift = '0;
    logic       p_presence = 1'b0;
    logic       p_drive = 1'b0;
    logic [7:0] p_read = '0;

    // Durations beyond the timer saturate at its largest count.
    function automatic logic [9:0] limit_time(logic [9:0] v);
        int unsigned top;
        top = (1 << TMR_BITS) - 1;
        return (v > top) ? top[9:0] : v;
    endfunction

    // Enters a phase: sets the line drive and loads the phase duration.
    function automatic void enter_phase(logic [3:0] next);
        logic [9:0] dur;
        dur = '0;
        p_phase = next;
        p_drive = 1'b0;
        case (next)
            PH_RST_LOW:    begin dur = timing.reset_low_time; p_drive = 1'b1; end
            PH_RST_WAIT:   dur = timing.presence_wait_time;
            PH_RST_REC:    dur = timing.reset_recovery_time;
            PH_GUARD_PRE:  dur = timing.guard_time;
            PH_SLOT_START: begin dur = timing.slot_start_time; p_drive = 1'b1; end
            PH_W_HOLD:     begin dur = timing.slot_hold_time; p_drive = ~p_shift[0]; end
            PH_GUARD_POST: dur = timing.guard_time;
            PH_R_DELAY:    dur = timing.read_sample_delay;
            PH_R_HOLD:     dur = timing.slot_hold_time;
            default:       p_phase = PH_IDLE;
        endcase
        p_left = limit_time(dur);
    endfunction

    // The current phase has run out. Exit actions run, and zero-length
    // phases fall through, until a phase with time left or idle is reached.
    // Returns 1 when the operation completes.
    function automatic bit close_phases(logic line);
        while (1'b1)
        begin
            case (p_phase)
                PH_RST_LOW:    enter_phase(PH_RST_WAIT);
                PH_RST_WAIT:
                begin
                    p_presence = ~line;
                    enter_phase(PH_RST_REC);
                end
                PH_GUARD_PRE:  enter_phase(PH_SLOT_START);
                PH_SLOT_START: enter_phase((p_op == ACT_WRITE) ? PH_W_HOLD : PH_R_DELAY);
                PH_W_HOLD:     enter_phase(PH_GUARD_POST);
                PH_R_DELAY:
                begin
                    p_shift = {line, p_shift[7:1]};
                    enter_phase(PH_R_HOLD);
                end
                PH_GUARD_POST, PH_R_HOLD:
                begin
                    if (p_phase == PH_GUARD_POST)
                        p_shift = p_shift >> 1;
                    p_bits = p_bits + 4'd1;
                    if (p_bits >= 4'd8)
                    begin
                        if (p_op == ACT_READ)
                            p_read = p_shift;
                        enter_phase(PH_IDLE);
                        return 1'b1;
                    end
                    enter_phase(PH_GUARD_PRE);
                end
                default:
                begin
                    // End of recovery.
                    enter_phase(PH_IDLE);
                    return 1'b1;
                end
            endcase
            if (p_left != 0)
                return 1'b0;
        end
        return 1'b0;
    endfunction

    // Advances the model by one command transaction and returns its result.
    function automatic out_item_t predict_bus(in_item_t it);
        out_item_t r;
        bit        fin;
        fin = 1'b0;
        if (it.action == ACT_TICK)
        begin
            if (p_phase != PH_IDLE)
            begin
                if (p_left > 0)
                    p_left = p_left - 10'd1;
                if (p_left == 0)
                    fin = close_phases(it.line_level);
            end
        end
        else if (p_phase == PH_IDLE)
        begin
            p_op = it.action;
            p_bits = '0;
            if (it.action == ACT_RESET)
                enter_phase(PH_RST_LOW);
            else
            begin
                p_shift = (it.action == ACT_WRITE) ? it.data_byte : 8'h00;
                enter_phase(PH_GUARD_PRE);
            end
            if (p_left == 0)
                fin = close_phases(it.line_level);
        end
        r.drive_low = p_drive;
        r.busy_res  = (p_phase != PH_IDLE);
        r.done_res  = fin;
        r.presence  = p_presence;
        r.read_data = p_read;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table. Result columns: drive_low, busy, done, presence, data.
    // ------------------------------------------------------------------------
    function automatic dir_row_t row_item(logic [1:0] act, logic [7:0] data, logic line);
        return '{ROW_ITEM, 3'd0, 10'd0, '{act, data, line}, 1'b0, '0};
    endfunction

    function automatic dir_row_t row_typed(logic [1:0] act, logic [7:0] data, logic line,
                                           out_item_t want);
        return '{ROW_ITEM, 3'd0, 10'd0, '{act, data, line}, 1'b1, want};
    endfunction

    function automatic dir_row_t row_cfg(row_kind_t kind, logic [2:0] idx, logic [9:0] val);
        return '{kind, idx, val, '0, 1'b0, '0};
    endfunction

    dir_row_t dir_tab [DIR_ROWS] = '{
        // State after reset: idle ticks change nothing.
        row_typed(ACT_TICK,  8'h00, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}),
        row_typed(ACT_TICK,  8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}),
        // Zero timings: whole operations finish on the command itself.
        row_cfg(ROW_CFG_ALL, 3'd0, 10'd0),
        // The unused index must leave every timing at zero.
        row_cfg(ROW_CFG_ONE, CFG_UNUSED, 10'd1023),
        row_typed(ACT_RESET, 8'h00, 1'b0, '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00}),
        row_typed(ACT_RESET, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}),
        row_typed(ACT_WRITE, 8'hFF, 1'b0, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}),
        row_typed(ACT_READ,  8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF}),
        row_typed(ACT_READ,  8'hFF, 1'b0, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}),
        row_typed(ACT_READ,  8'h55, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF}),
        row_typed(ACT_WRITE, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF}),
        row_typed(ACT_TICK,  8'h00, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 8'hFF}),
        // One-microsecond timings: reset pulse, ignored command, presence.
        row_cfg(ROW_CFG_ALL, 3'd0, 10'd1),
        row_typed(ACT_RESET, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'hFF}),
        row_typed(ACT_WRITE, 8'h5A, 1'b0, '{1'b1, 1'b1, 1'b0, 1'b0, 8'hFF}),
        row_item(ACT_TICK,  8'h00, 1'b0),
        row_item(ACT_TICK,  8'h00, 1'b0),
        row_item(ACT_TICK,  8'h00, 1'b1),
        row_item(ACT_READ,  8'h00, 1'b0),
        row_item(ACT_WRITE, 8'hAA, 1'b1),
        row_item(ACT_TICK,  8'h00, 1'b1),
        // No guard gap around write slots.
        row_cfg(ROW_CFG_ONE, CFG_GUARD, 10'd0),
        row_item(ACT_WRITE, 8'h80, 1'b0),
        row_item(ACT_TICK,  8'h00, 1'b0),
        row_item(ACT_TICK,  8'h00, 1'b1)
    };

    // ------------------------------------------------------------------------
    // Clock, timeout and receiver.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("one_wire_bus_master test failed");
        $finish;
    end

    // The receiver stalls at random, or holds off for a long stretch on
    // request so that both registers of the block fill and cmd_stall rises.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                res_stall <= ($urandom_range(0, 99) < rcv_idle);
        end
    end

    // Each accepted result transaction is checked against the oldest expectation.
    out_item_t oldest;
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_res.size() == 0)
            begin
                err_count++;
                if (shown < MAX_SHOWN)
                begin
                    shown++;
                    $display("unexpected result transaction %p", res_item);
                end
            end
            else
            begin
                oldest = pending_res.pop_front();
                if (res_item.drive_low !== oldest.drive_low ||
                    res_item.busy_res  !== oldest.busy_res  ||
                    res_item.done_res  !== oldest.done_res  ||
                    res_item.presence  !== oldest.presence  ||
                    res_item.read_data !== oldest.read_data)
                begin
                    err_count++;
                    if (shown < MAX_SHOWN)
                    begin
                        shown++;
                        $display("mismatch: expected drive=%0b busy=%0b done=%0b pres=%0b data=%02h",
                                 oldest.drive_low, oldest.busy_res, oldest.done_res,
                                 oldest.presence, oldest.read_data);
                        $display("          actual   drive=%0b busy=%0b done=%0b pres=%0b data=%02h",
                                 res_item.drive_low, res_item.busy_res, res_item.done_res,
                                 res_item.presence, res_item.read_data);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------
    function automatic in_item_t rand_item(logic [1:0] act);
        in_item_t it;
        it.action     = act;
        it.data_byte  = 8'($urandom_range(0, 255));
        it.line_level = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Mostly very short timings so that many operations fit, zero now and then.
    function automatic logic [9:0] short_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 10'd0;
        else if (r < 9)
            return 10'($urandom_range(1, 2));
        return 10'($urandom_range(3, 12));
    endfunction

    function automatic cfg_t rand_timing();
        return '{short_time(), short_time(), short_time(), short_time(),
                 short_time(), short_time(), short_time()};
    endfunction

    // Predicts one transaction, queues its expectation and offers it until
    // the block accepts it. Valid stays high after acceptance; the next call
    // or the end of a phase decides whether it drops.
    task automatic send_cmd(in_item_t it, bit typed, out_item_t want);
        int        gap;
        out_item_t pred;
        bit        moves;
        moves = ((p_phase != PH_IDLE) == (it.action == ACT_TICK));
        pred = predict_bus(it);
        if (moves)
            timed_items++;
        pending_res.push_back(typed ? want : pred);
        gap = ($urandom_range(0, 99) < snd_idle) ? int'($urandom_range(1, 3)) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Lets any running operation finish, then waits until every result is in
    // and the pipeline has had time to empty.
    task automatic quiesce();
        while (p_phase != PH_IDLE)
            send_cmd(rand_item(ACT_TICK), 1'b0, '0);
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [9:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_RESET_LOW:     timing.reset_low_time      = val;
            CFG_PRESENCE_WAIT: timing.presence_wait_time  = val;
            CFG_RESET_REC:     timing.reset_recovery_time = val;
            CFG_SLOT_START:    timing.slot_start_time     = val;
            CFG_SLOT_HOLD:     timing.slot_hold_time      = val;
            CFG_READ_SAMPLE:   timing.read_sample_delay   = val;
            CFG_GUARD:         timing.guard_time          = val;
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_timing(cfg_t t);
        quiesce();
        write_reg(CFG_RESET_LOW,     t.reset_low_time);
        write_reg(CFG_PRESENCE_WAIT, t.presence_wait_time);
        write_reg(CFG_RESET_REC,     t.reset_recovery_time);
        write_reg(CFG_SLOT_START,    t.slot_start_time);
        write_reg(CFG_SLOT_HOLD,     t.slot_hold_time);
        write_reg(CFG_READ_SAMPLE,   t.read_sample_delay);
        write_reg(CFG_GUARD,         t.guard_time);
        close_writes();
    endtask

    // One timing setting: operations are sent as a command followed by ticks
    // until the model goes idle, with random bus levels throughout. Stray
    // commands during an operation and idle ticks between operations are the
    // noise. The first operation is lead unless lead is a tick.
    task automatic run_phase(cfg_t t, logic [1:0] lead, int ops_min, int timed_min,
                             bit hold_off);
        int         ops;
        int         timed_start;
        logic [1:0] act;
        program_timing(t);
        ops = 0;
        timed_start = timed_items;
        if (hold_off)
            hold_req = 1'b1;
        while (ops < ops_min || timed_items - timed_start < timed_min)
        begin
            if ($urandom_range(0, 9) == 0)
                send_cmd(rand_item(ACT_TICK), 1'b0, '0);
            act = (ops == 0 && lead != ACT_TICK) ? lead : 2'($urandom_range(1, 3));
            send_cmd(rand_item(act), 1'b0, '0);
            ops++;
            while (p_phase != PH_IDLE)
            begin
                act = ($urandom_range(0, 99) < 8) ? 2'($urandom_range(1, 3)) : ACT_TICK;
                send_cmd(rand_item(act), 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_t all_t;
        int   i;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender idles less than the receiver first.
        snd_idle = 35;
        rcv_idle = 55;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            case (dir_tab[i].kind)
                ROW_ITEM:
                    send_cmd(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
                ROW_CFG_ALL:
                begin
                    all_t = '{default: dir_tab[i].reg_val};
                    program_timing(all_t);
                end
                default:
                begin
                    quiesce();
                    write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
                    close_writes();
                end
            endcase
        end

        // Lowest legal values, then random short settings.
        run_phase('{10'd1, 10'd1, 10'd0, 10'd1, 10'd1, 10'd0, 10'd0}, ACT_RESET, 3, 0, 1'b0);
        run_phase(rand_timing(), ACT_TICK, 3, TIMED_MIN, 1'b0);
        run_phase(rand_timing(), ACT_TICK, 3, TIMED_MIN, 1'b0);

        // Receiver idles less than the sender.
        snd_idle = 55;
        rcv_idle = 35;
        run_phase(rand_timing(), ACT_TICK, 3, TIMED_MIN, 1'b0);
        run_phase(rand_timing(), ACT_TICK, 3, TIMED_MIN, 1'b0);

        // No idling; the first phase starts with a long receiver hold-off.
        snd_idle = 0;
        rcv_idle = 0;
        run_phase(rand_timing(), ACT_WRITE, 3, TIMED_MIN, 1'b1);
        run_phase(rand_timing(), ACT_TICK, 3, TIMED_MIN, 1'b0);
        run_phase(rand_timing(), ACT_TICK, 3, TIMED_MIN, 1'b0);

        quiesce();
        if (err_count == 0)
            $display("one_wire_bus_master test passed");
        else
            $display("one_wire_bus_master test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/owb_pkg.sv
rtl/core/owb_cfg_regs.sv
rtl/core/owb_step.sv
rtl/core/one_wire_bus_master.sv
tb/one_wire_bus_master_test.sv
